[rtl/btfd_pkg.sv]
// Shared types and constants for the battery telemetry frame decoder.
// No dependencies; every other file of the block imports this package.
package btfd_pkg;

	localparam int unsigned FRAME_LEN = 30;
	localparam int unsigned XOR_LEN   = 28;

	localparam logic [4:0] CNT_FRAME = 5'd30;
	localparam logic [4:0] CNT_XOR   = 5'd28;
	localparam logic [4:0] CNT_MAX   = 5'd31;

	localparam logic [7:0] BYTE_HEADER = 8'hFB;
	localparam logic [7:0] BYTE_TYPE   = 8'h01;
	localparam logic [7:0] BYTE_LEN    = 8'h19;
	localparam logic [7:0] BYTE_TAIL   = 8'hFD;

	// status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_LENGTH    = 4'd1;
	localparam logic [3:0] ST_HEADER    = 4'd2;
	localparam logic [3:0] ST_TYPE      = 4'd3;
	localparam logic [3:0] ST_LENBYTE   = 4'd4;
	localparam logic [3:0] ST_TAIL      = 4'd5;
	localparam logic [3:0] ST_XOR       = 4'd6;
	localparam logic [3:0] ST_STATE     = 4'd7;
	localparam logic [3:0] ST_P_VOLT    = 4'd8;
	localparam logic [3:0] ST_P_CURR    = 4'd9;
	localparam logic [3:0] ST_P_SOC     = 4'd10;
	localparam logic [3:0] ST_P_SOH     = 4'd11;
	localparam logic [3:0] ST_P_MOS     = 4'd12;
	localparam logic [3:0] ST_P_ENV     = 4'd13;
	localparam logic [3:0] ST_LIM_VOLT  = 4'd14;
	localparam logic [3:0] ST_LIM_OTHER = 4'd15;

	// register indexes
	localparam logic [2:0] REG_BIG_ENDIAN = 3'd0;
	localparam logic [2:0] REG_MIN_VOLT   = 3'd1;
	localparam logic [2:0] REG_MAX_VOLT   = 3'd2;
	localparam logic [2:0] REG_MAX_CURR   = 3'd3;
	localparam logic [2:0] REG_MIN_TEMP   = 3'd4;
	localparam logic [2:0] REG_MAX_TEMP   = 3'd5;

	// fixed plausibility bounds
	localparam logic [31:0]        VOLT_LO  = 32'd5000;
	localparam logic [31:0]        VOLT_HI  = 32'd100000;
	localparam logic [31:0]        CURR_HI  = 32'd500000;
	localparam logic [15:0]        SOC_HI   = 16'd1000;
	localparam logic [7:0]         SOH_HI   = 8'd100;
	localparam logic [7:0]         CS_HI    = 8'd2;
	localparam logic [7:0]         CS_CHG   = 8'd1;
	localparam logic signed [15:0] TEMP_LO  = -16'sd600;
	localparam logic signed [15:0] TEMP_HI  = 16'sd1500;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	typedef struct packed {
		logic               big_endian;
		logic [16:0]        min_voltage_mv;
		logic [16:0]        max_voltage_mv;
		logic [18:0]        max_abs_current_ma;
		logic signed [11:0] min_temp_tenths;
		logic signed [11:0] max_temp_tenths;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] count;
		logic [7:0] xsum;
	} pend_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [16:0] voltage_mv;
		logic [19:0] current_ma;
		logic [9:0]  soc_tenths;
		logic [6:0]  health_pct;
		logic [1:0]  charge_state;
		logic [11:0] mos_temp_tenths;
		logic [11:0] env_temp_tenths;
		logic [31:0] warning_word;
		logic [31:0] protection_word;
		logic        charging;
		logic        fault;
	} result_t;

endpackage

[rtl/battery_telemetry_frame_decoder_core.sv]
// Top level of the battery telemetry frame decoder: configuration registers,
// stream handshake and result register. Depends on btfd_pkg, btfd_capture, btfd_eval.
//
// channel  | dir | beat                         | payload
// s_axis   | in  | s_axis_tvalid & s_axis_tready | tdata: data_byte; tlast: last_byte
// m_axis   | out | m_axis_tvalid & m_axis_tready | tuser: status; tdata: decoded fields
// cfg      | in  | cfg_valid & cfg_ready         | cfg_index, cfg_data
//
// One byte is taken per cycle unless input stalls. A last byte puts the
// frame in a check stage, whose combinational check loads the result register
// as the stage advances. The check stage holds while the result register is
// full and not taken, and input then stalls. Reset clears the
// counter, the XOR, both stage valids and loads the register defaults.
module battery_telemetry_frame_decoder_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
	input  logic          s_axis_tlast,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [151:0]  m_axis_tdata,   // [16:0] voltage_mv, [36:17] current_ma,
	                                      // [46:37] soc_tenths, [53:47] health_pct,
	                                      // [55:54] charge_state, [67:56] mos_temp_tenths,
	                                      // [79:68] env_temp_tenths, [111:80] warning_word,
	                                      // [143:112] protection_word, [144] charging,
	                                      // [145] fault, [151:146] zero
	output logic [3:0]    m_axis_tuser,   // [3:0] status
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [18:0]   cfg_data
);
	import btfd_pkg::*;

	cfg_t    cfg_q;
	frame_t  frame;
	pend_t   pend;
	result_t result;
	result_t out_q;
	logic    out_valid_q;
	logic    advance;
	logic    beat;

	assign cfg_ready     = 1'b1;
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !pend.valid || advance;
	assign beat          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.big_endian         <= 1'b1;
			cfg_q.min_voltage_mv     <= 17'd15000;
			cfg_q.max_voltage_mv     <= 17'd35000;
			cfg_q.max_abs_current_ma <= 19'd200000;
			cfg_q.min_temp_tenths    <= -12'sd400;
			cfg_q.max_temp_tenths    <= 12'sd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BIG_ENDIAN: cfg_q.big_endian         <= cfg_data[0];
				REG_MIN_VOLT:   cfg_q.min_voltage_mv     <= cfg_data[16:0];
				REG_MAX_VOLT:   cfg_q.max_voltage_mv     <= cfg_data[16:0];
				REG_MAX_CURR:   cfg_q.max_abs_current_ma <= cfg_data[18:0];
				REG_MIN_TEMP:   cfg_q.min_temp_tenths    <= $signed(cfg_data[11:0]);
				REG_MAX_TEMP:   cfg_q.max_temp_tenths    <= $signed(cfg_data[11:0]);
				default: ;
			endcase
		end
	end

	btfd_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.advance   (advance),
		.frame     (frame),
		.pend      (pend)
	);

	btfd_eval u_eval (
		.frame  (frame),
		.pend   (pend),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= pend.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pend.valid) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {6'd0, out_q.fault, out_q.charging, out_q.protection_word,
			out_q.warning_word, out_q.env_temp_tenths, out_q.mos_temp_tenths,
			out_q.charge_state, out_q.health_pct, out_q.soc_tenths,
			out_q.current_ma, out_q.voltage_mv};

endmodule

[rtl/btfd_capture.sv]
// Byte capture: byte counter, running XOR, frame byte store and the stage
// that holds a finished frame for checking. Depends on btfd_pkg.
module btfd_capture (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beat,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  logic             advance,
	output btfd_pkg::frame_t frame,
	output btfd_pkg::pend_t  pend
);
	import btfd_pkg::*;

	logic [4:0] count_q;
	logic [7:0] xsum_q;
	logic [7:0] store_q [FRAME_LEN];
	pend_t      pend_s1;
	logic [4:0] count_next;
	logic [7:0] xsum_next;

	always_comb begin
		count_next = (count_q == CNT_MAX) ? CNT_MAX : count_q + 5'd1;
		xsum_next  = (count_q < CNT_XOR) ? (xsum_q ^ data_byte) : xsum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			xsum_q  <= '0;
		end else if (beat) begin
			if (last_byte) begin
				count_q <= '0;
				xsum_q  <= '0;
			end else begin
				count_q <= count_next;
				xsum_q  <= xsum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat && (count_q < CNT_FRAME)) begin
			store_q[count_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (beat && last_byte) begin
			pend_s1.valid <= 1'b1;
			pend_s1.count <= count_next;
			pend_s1.xsum  <= xsum_next;
		end else if (advance) begin
			pend_s1.valid <= 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < FRAME_LEN; i++) begin
			frame[i] = store_q[i];
		end
	end

	assign pend = pend_s1;

endmodule

[rtl/btfd_eval.sv]
// Frame check and field decode: framing checks, endian decode, plausibility
// and configured limits, in one pass. Depends on btfd_pkg.
module btfd_eval (
	input  btfd_pkg::frame_t  frame,
	input  btfd_pkg::pend_t   pend,
	input  btfd_pkg::cfg_t    cfg,
	output btfd_pkg::result_t result
);
	import btfd_pkg::*;

	function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
			input logic big);
		return big ? {b0, b1} : {b1, b0};
	endfunction

	function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic big);
		return big ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
	endfunction

	logic               big;
	logic [31:0]        volt;
	logic [31:0]        cur;
	logic [31:0]        acur;
	logic [15:0]        soc;
	logic [7:0]         soh;
	logic [7:0]         cs;
	logic signed [15:0] tm;
	logic signed [15:0] te;
	logic [31:0]        warn;
	logic [31:0]        prot;
	logic signed [15:0] tmin;
	logic signed [15:0] tmax;
	logic [3:0]         status;

	always_comb begin
		big  = cfg.big_endian;
		volt = get32(frame[3], frame[4], frame[5], frame[6], big);
		cur  = get32(frame[7], frame[8], frame[9], frame[10], big);
		acur = cur[31] ? (32'd0 - cur) : cur;
		soc  = get16(frame[11], frame[12], big);
		soh  = frame[13];
		cs   = frame[14];
		tm   = $signed(get16(frame[15], frame[16], big));
		te   = $signed(get16(frame[17], frame[18], big));
		warn = {get16(frame[19], frame[20], big), get16(frame[21], frame[22], big)};
		prot = {get16(frame[23], frame[24], big), get16(frame[25], frame[26], big)};
		tmin = {{4{cfg.min_temp_tenths[11]}}, cfg.min_temp_tenths};
		tmax = {{4{cfg.max_temp_tenths[11]}}, cfg.max_temp_tenths};

		if (pend.count != CNT_FRAME)                       status = ST_LENGTH;
		else if (frame[0] != BYTE_HEADER)                  status = ST_HEADER;
		else if (frame[1] != BYTE_TYPE)                    status = ST_TYPE;
		else if (frame[2] != BYTE_LEN)                     status = ST_LENBYTE;
		else if (frame[29] != BYTE_TAIL)                   status = ST_TAIL;
		else if (pend.xsum != frame[28])                   status = ST_XOR;
		else if (cs > CS_HI)                               status = ST_STATE;
		else if (volt < VOLT_LO || volt > VOLT_HI)         status = ST_P_VOLT;
		else if (acur > CURR_HI)                           status = ST_P_CURR;
		else if (soc > SOC_HI)                             status = ST_P_SOC;
		else if (soh > SOH_HI)                             status = ST_P_SOH;
		else if (tm < TEMP_LO || tm > TEMP_HI)             status = ST_P_MOS;
		else if (te < TEMP_LO || te > TEMP_HI)             status = ST_P_ENV;
		else if (volt < {15'd0, cfg.min_voltage_mv} ||
				volt > {15'd0, cfg.max_voltage_mv})         status = ST_LIM_VOLT;
		else if (acur > {13'd0, cfg.max_abs_current_ma} ||
				tm < tmin || tm > tmax || te < tmin || te > tmax)
			status = ST_LIM_OTHER;
		else                                               status = ST_OK;

		result = '0;
		result.status = status;
		if (status == ST_OK) begin
			result.voltage_mv      = volt[16:0];
			result.current_ma      = cur[19:0];
			result.soc_tenths      = soc[9:0];
			result.health_pct      = soh[6:0];
			result.charge_state    = cs[1:0];
			result.mos_temp_tenths = tm[11:0];
			result.env_temp_tenths = te[11:0];
			result.warning_word    = warn;
			result.protection_word = prot;
			result.charging        = (cs == CS_CHG) && (prot == 32'd0);
			result.fault           = (warn != 32'd0) || (prot != 32'd0);
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for battery_telemetry_frame_decoder_core: streams frames with
// random idling on both sides and checks every decoded result. Depends on btfd_pkg.

import btfd_pkg::*;

class frame_result_ledger;
	bit          big;
	int          vmin, vmax, imax, tmin, tmax;
	logic [4:0]  cnt;
	logic [7:0]  xsum;
	logic [7:0]  fb [FRAME_LEN];
	result_t     awaited [$];
	int unsigned errors, checked;
	logic [15:0] seen;

	function new();
		big = 1'b1;
		vmin = 15000;
		vmax = 35000;
		imax = 200000;
		tmin = -400;
		tmax = 1000;
		cnt = '0;
		xsum = '0;
		errors = 0;
		checked = 0;
		seen = '0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [18:0] val);
		case (idx)
			REG_BIG_ENDIAN: big = val[0];
			REG_MIN_VOLT: vmin = int'(val[16:0]);
			REG_MAX_VOLT: vmax = int'(val[16:0]);
			REG_MAX_CURR: imax = int'(val[18:0]);
			REG_MIN_TEMP: tmin = int'($signed(val[11:0]));
			REG_MAX_TEMP: tmax = int'($signed(val[11:0]));
			default: ;
		endcase
	endfunction

	function logic [31:0] fetch(int unsigned at, int unsigned size);
		logic [31:0] v;
		v = '0;
		for (int unsigned i = 0; i < size; i++) begin
			if (big)
				v = {v[23:0], fb[at + i]};
			else
				v = v | (32'(fb[at + i]) << (8 * i));
		end
		return v;
	endfunction

	function void take_byte(logic [7:0] d, logic l);
		result_t     r;
		logic [31:0] volt, warn, prot, w;
		logic [15:0] soc;
		logic [7:0]  soh, st;
		longint      cur, acur;
		int          tm, te;
		if (cnt < CNT_FRAME) fb[cnt] = d;
		if (cnt < CNT_XOR) xsum = xsum ^ d;
		if (cnt < CNT_MAX) cnt = cnt + 5'd1;
		if (!l) return;
		r = '0;
		if (cnt != CNT_FRAME) r.status = ST_LENGTH;
		else if (fb[0] != BYTE_HEADER) r.status = ST_HEADER;
		else if (fb[1] != BYTE_TYPE) r.status = ST_TYPE;
		else if (fb[2] != BYTE_LEN) r.status = ST_LENBYTE;
		else if (fb[29] != BYTE_TAIL) r.status = ST_TAIL;
		else if (xsum != fb[28]) r.status = ST_XOR;
		else begin
			volt = fetch(3, 4);
			w = fetch(7, 4);
			cur = longint'($signed(w));
			w = fetch(11, 2);
			soc = w[15:0];
			soh = fb[13];
			st = fb[14];
			w = fetch(15, 2);
			tm = int'($signed(w[15:0]));
			w = fetch(17, 2);
			te = int'($signed(w[15:0]));
			warn = {fetch(19, 2) << 16} | fetch(21, 2);
			prot = {fetch(23, 2) << 16} | fetch(25, 2);
			acur = (cur < 0) ? -cur : cur;
			if (st > CS_HI) r.status = ST_STATE;
			else if (volt < VOLT_LO || volt > VOLT_HI) r.status = ST_P_VOLT;
			else if (acur > longint'(CURR_HI)) r.status = ST_P_CURR;
			else if (soc > SOC_HI) r.status = ST_P_SOC;
			else if (soh > SOH_HI) r.status = ST_P_SOH;
			else if (tm < TEMP_LO || tm > TEMP_HI) r.status = ST_P_MOS;
			else if (te < TEMP_LO || te > TEMP_HI) r.status = ST_P_ENV;
			else if (longint'(volt) < vmin || longint'(volt) > vmax) r.status = ST_LIM_VOLT;
			else if (acur > imax || tm < tmin || tm > tmax || te < tmin || te > tmax)
				r.status = ST_LIM_OTHER;
			else begin
				r.status = ST_OK;
				r.voltage_mv = volt[16:0];
				r.current_ma = 20'(cur);
				r.soc_tenths = soc[9:0];
				r.health_pct = soh[6:0];
				r.charge_state = st[1:0];
				r.mos_temp_tenths = 12'(tm);
				r.env_temp_tenths = 12'(te);
				r.warning_word = warn;
				r.protection_word = prot;
				r.charging = (st == CS_CHG) && (prot == '0);
				r.fault = (warn != '0) || (prot != '0);
			end
		end
		awaited.push_back(r);
		cnt = '0;
		xsum = '0;
	endfunction

	function void cmp(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			errors++;
		end
	endfunction

	function void match_result(logic [3:0] tu, logic [151:0] td);
		result_t e;
		if (awaited.size() == 0) begin
			$error("result beat with no frame pending: status %0d", tu);
			errors++;
			return;
		end
		e = awaited.pop_front();
		checked++;
		seen[e.status] = 1'b1;
		cmp("status", e.status, tu);
		cmp("voltage_mv", e.voltage_mv, td[16:0]);
		cmp("current_ma", e.current_ma, td[36:17]);
		cmp("soc_tenths", e.soc_tenths, td[46:37]);
		cmp("health_pct", e.health_pct, td[53:47]);
		cmp("charge_state", e.charge_state, td[55:54]);
		cmp("mos_temp_tenths", e.mos_temp_tenths, td[67:56]);
		cmp("env_temp_tenths", e.env_temp_tenths, td[79:68]);
		cmp("warning_word", e.warning_word, td[111:80]);
		cmp("protection_word", e.protection_word, td[143:112]);
		cmp("charging", e.charging, td[144]);
		cmp("fault", e.fault, td[145]);
	endfunction

	function int unsigned pending();
		return awaited.size();
	endfunction
endclass

module testbench;
	localparam int unsigned WATCHDOG_CYCLES = 2000;
	localparam int unsigned PHASE_BYTES = 135;

	typedef enum {MUT_NONE, MUT_HEADER, MUT_TYPE, MUT_LENBYTE, MUT_TAIL, MUT_XOR} mutation_t;

	typedef struct packed {
		logic [31:0] volt;
		logic [31:0] cur;
		logic [15:0] soc;
		logic [7:0]  soh;
		logic [7:0]  st;
		logic [15:0] tm;
		logic [15:0] te;
		logic [31:0] warn;
		logic [31:0] prot;
		logic [7:0]  spare;
	} telem_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [7:0]    s_axis_tdata = '0;   // [7:0] data_byte
	logic          s_axis_tlast = 1'b0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [151:0]  m_axis_tdata;        // [16:0] voltage_mv ... [145] fault, see dut
	logic [3:0]    m_axis_tuser;        // [3:0] status
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [2:0]    cfg_index = '0;
	logic [18:0]   cfg_data = '0;

	frame_result_ledger sb = new();
	cfg_t        cfg_now;
	cfg_t        settings [4];
	int unsigned src_pct = 0;
	int unsigned sink_pct = 0;
	int unsigned bytes_sent = 0;

	battery_telemetry_frame_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.match_result(m_axis_tuser, m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= sink_pct);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	task automatic send_byte(input logic [7:0] d, input logic l);
		if ($urandom_range(99) < src_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= l;
		do @(posedge clk); while (!s_axis_tready);
		sb.take_byte(d, l);
		bytes_sent++;
	endtask

	function automatic void place(inout frame_t f, input int unsigned at,
	                              input int unsigned size, input logic [31:0] v);
		for (int unsigned i = 0; i < size; i++)
			f[at + i] = cfg_now.big_endian ? 8'(v >> (8 * (size - 1 - i))) : 8'(v >> (8 * i));
	endfunction

	task automatic send_frame(input telem_t t, input mutation_t m, input int unsigned len);
		frame_t      f;
		logic [7:0]  x;
		f = '0;
		f[0] = BYTE_HEADER;
		f[1] = BYTE_TYPE;
		f[2] = BYTE_LEN;
		place(f, 3, 4, t.volt);
		place(f, 7, 4, t.cur);
		place(f, 11, 2, t.soc);
		f[13] = t.soh;
		f[14] = t.st;
		place(f, 15, 2, t.tm);
		place(f, 17, 2, t.te);
		place(f, 19, 2, t.warn[31:16]);
		place(f, 21, 2, t.warn[15:0]);
		place(f, 23, 2, t.prot[31:16]);
		place(f, 25, 2, t.prot[15:0]);
		f[27] = t.spare;
		x = '0;
		for (int unsigned i = 0; i < XOR_LEN; i++)
			x = x ^ f[i];
		f[28] = x;
		f[29] = BYTE_TAIL;
		x = 8'($urandom_range(255, 1));
		case (m)
			MUT_HEADER: f[0] = f[0] ^ x;
			MUT_TYPE: f[1] = f[1] ^ x;
			MUT_LENBYTE: f[2] = f[2] ^ x;
			MUT_TAIL: f[29] = f[29] ^ x;
			MUT_XOR: f[28] = f[28] ^ x;
			default: ;
		endcase
		for (int unsigned i = 0; i < len; i++)
			send_byte((i < FRAME_LEN) ? f[i] : 8'($urandom()), i == len - 1);
	endtask

	function automatic int span(int lo, int hi);
		if (lo > hi)
			return hi + int'($urandom_range(lo - hi));
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic telem_t nominal();
		telem_t t;
		t.volt = 32'd25000;
		t.cur = -32'sd1500;
		t.soc = 16'd500;
		t.soh = 8'd90;
		t.st = 8'd1;
		t.tm = 16'sd250;
		t.te = 16'sd200;
		t.warn = '0;
		t.prot = '0;
		t.spare = 8'h5A;
		return t;
	endfunction

	task automatic send_random_frame();
		telem_t      t;
		mutation_t   m;
		int unsigned len, roll;
		int          vlo, vhi, ilim, tlo, thi;
		vlo = int'(cfg_now.min_voltage_mv);
		vhi = int'(cfg_now.max_voltage_mv);
		ilim = int'(cfg_now.max_abs_current_ma);
		tlo = int'(cfg_now.min_temp_tenths);
		thi = int'(cfg_now.max_temp_tenths);
		if (vlo < 5000) vlo = 5000;
		if (vhi > 100000) vhi = 100000;
		if (ilim > 500000) ilim = 500000;
		if (tlo < -600) tlo = -600;
		if (thi > 1500) thi = 1500;
		// mostly in range, sometimes far out or just past a fixed bound
		if ($urandom_range(19) == 0)
			t.volt = $urandom_range(1) ? $urandom() : ($urandom_range(1) ? 32'd4999 : 32'd100001);
		else
			t.volt = 32'(span(vlo, vhi));
		if ($urandom_range(19) == 0)
			t.cur = $urandom_range(1) ? $urandom() : ($urandom_range(1) ? 32'd500001 : -32'sd500001);
		else
			t.cur = 32'(span(-ilim, ilim));
		t.soc = ($urandom_range(19) == 0) ? 16'($urandom()) : 16'(span(0, 1000));
		t.soh = ($urandom_range(19) == 0) ? 8'($urandom()) : 8'(span(0, 100));
		t.st = ($urandom_range(19) == 0) ? 8'($urandom()) : 8'(span(0, 2));
		t.tm = ($urandom_range(19) == 0) ? 16'($urandom()) : 16'(span(tlo, thi));
		t.te = ($urandom_range(19) == 0) ? 16'($urandom()) : 16'(span(tlo, thi));
		t.warn = $urandom_range(1) ? 32'd0 : $urandom();
		t.prot = $urandom_range(1) ? 32'd0 : $urandom();
		t.spare = 8'($urandom());
		roll = $urandom_range(99);
		m = MUT_NONE;
		len = FRAME_LEN;
		if (roll < 8)
			len = $urandom_range(1) ? $urandom_range(29, 1) : $urandom_range(45, 31);
		else if (roll < 23)
			m = mutation_t'($urandom_range(5, 1));
		send_frame(t, m, len);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_settings(input cfg_t c);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_BIG_ENDIAN, 19'(c.big_endian));
		write_reg(REG_MIN_VOLT, 19'(c.min_voltage_mv));
		write_reg(REG_MAX_VOLT, 19'(c.max_voltage_mv));
		write_reg(REG_MAX_CURR, c.max_abs_current_ma);
		write_reg(REG_MIN_TEMP, 19'(c.min_temp_tenths));
		write_reg(REG_MAX_TEMP, 19'(c.max_temp_tenths));
		cfg_valid <= 1'b0;
		cfg_now = c;
		@(posedge clk);
	endtask

	initial begin
		telem_t      t;
		mutation_t   m;
		int unsigned len, mark;
		cfg_now = '{1'b1, 17'd15000, 17'd35000, 19'd200000, -12'sd400, 12'sd1000};
		settings[0] = '{1'b0, 17'd0, 17'd100000, 19'd500000, -12'sd600, 12'sd1500};
		settings[1] = '{1'b1, 17'd20000, 17'd30000, 19'd100000, -12'sd100, 12'sd500};
		settings[2] = '{1'b0, 17'd100000, 17'd5000, 19'd0, 12'sd1500, -12'sd600};
		settings[3] = '{1'b1, 17'd0, 17'h1FFFF, 19'h7FFFF, -12'sd2048, 12'sd2047};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset settings
		for (int k = 0; k < 29; k++) begin
			t = nominal();
			m = MUT_NONE;
			len = FRAME_LEN;
			case (k)
				1: begin t.st = 8'd2; t.warn = 32'h8000_0001; t.prot = 32'h0001_0000; end
				2: t.prot = 32'h0000_0004;
				3: begin
					t.volt = 32'd15000; t.cur = -32'sd200000; t.soc = '0; t.soh = '0;
					t.st = 8'd0; t.tm = -16'sd400; t.te = -16'sd400;
				end
				4: begin
					t.volt = 32'd35000; t.cur = 32'd200000; t.soc = 16'd1000; t.soh = 8'd100;
					t.tm = 16'sd1000; t.te = 16'sd1000; t.warn = '1; t.prot = '1; t.spare = '1;
				end
				5: m = MUT_HEADER;
				6: m = MUT_TYPE;
				7: m = MUT_LENBYTE;
				8: m = MUT_TAIL;
				9: m = MUT_XOR;
				10: t.st = 8'd3;
				11: t.st = 8'd255;
				12: t.volt = 32'd4999;
				13: t.volt = 32'd100001;
				14: t.cur = 32'd500001;
				15: t.cur = 32'h8000_0000;
				16: t.soc = 16'd1001;
				17: t.soh = 8'd101;
				18: t.tm = -16'sd601;
				19: t.te = 16'sd1501;
				20: t.volt = 32'd14999;
				21: t.volt = 32'd35001;
				22: t.cur = -32'sd200001;
				23: t.tm = 16'sd1001;
				24: t.te = -16'sd401;
				25: len = 1;
				26: len = 29;
				27: len = 31;
				28: len = 45;
				default: ;
			endcase
			send_frame(t, m, len);
		end

		for (int p = 0; p < 4; p++) begin
			apply_settings(settings[p]);
			case (p)
				0: begin src_pct = 0; sink_pct = 0; end
				1: begin src_pct = 87; sink_pct = 0; end
				2: begin src_pct = 0; sink_pct = 87; end
				default: begin src_pct = 32; sink_pct = 32; end
			endcase
			mark = bytes_sent;
			while (bytes_sent - mark < PHASE_BYTES)
				send_random_frame();
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("summary: %0d bytes streamed, %0d frame results checked, 5 register settings",
		         bytes_sent, sb.checked);
		$display("summary: status codes seen (bit per code) %b", sb.seen);
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule

[sim.f]
rtl/btfd_pkg.sv
rtl/btfd_capture.sv
rtl/btfd_eval.sv
rtl/battery_telemetry_frame_decoder_core.sv
bench/testbench.sv
